// ----- hw/rtl/mpfe_pkg.sv -----
// Shared types and codes for the monochrome page framebuffer engine.
// No dependencies; imported by the core.
`timescale 1ns / 1ps
`default_nettype none

package mpfe_pkg;

   typedef enum logic [2:0] {
      FN_SET_PIXEL   = 3'd0,
      FN_CLEAR_AREA  = 3'd1,
      FN_INVERT_AREA = 3'd2,
      FN_READ_PIXEL  = 3'd3,
      FN_BLIT        = 3'd4,
      FN_CLEAR_ALL   = 3'd5,
      FN_INVERT_ALL  = 3'd6,
      FN_READ_BYTE   = 3'd7
   } func_type;

   typedef struct packed {
      func_type           func;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         area_width;
      logic [7:0]         area_height;
      logic [7:0]         image_byte;
   } req_type;

   typedef struct packed {
      logic       pixel_value;
      logic [7:0] byte_value;
   } rsp_type;

   // signed width that holds any corner of an area, with margin
   localparam int CoordW = 18;

endpackage

`default_nettype wire

// ----- hw/rtl/mpfe_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mpfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mono_page_framebuffer_engine_core.sv -----
// Page-organized monochrome framebuffer engine: one item in, one beat out.
// Depends on mpfe_pkg and mpfe_ram.
// Each item touches N bytes: 1 for pixel ops and byte read, up to 2 for blit,
// COLUMNS*PAGES for whole screen; an item that touches nothing skips the
// sweep. The next item is taken once the result is loaded; the RAM sweeps
// one byte per cycle, read and write overlapped on its two ports. After
// reset the core clears the store before it takes the first item.
`timescale 1ns / 1ps
`default_nettype none

module mono_page_framebuffer_engine_core #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire mpfe_pkg::req_type req_item,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      mpfe_pkg::rsp_type rsp_item
);

   import mpfe_pkg::*;

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLUMNS);
   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam logic signed [CoordW-1:0] COL_LAST = CoordW'(COLUMNS - 1);
   localparam logic signed [CoordW-1:0] ROW_LAST = CoordW'(PAGES * 8 - 1);
   localparam logic [CW-1:0]            COL_MAX  = CW'(COLUMNS - 1);
   localparam logic [PW-1:0]            PAGE_MAX = PW'(PAGES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CLIP,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   req_type   item_ff;
   func_type  func_ff;
   logic      quiet_ff;

   logic signed [CoordW-1:0] xa_ff, xb_ff, ya_ff, yb_ff;
   logic                     none_ff;
   logic [15:0]              shift_ff;

   logic [CW-1:0] c0_ff, c1_ff, col_ff;
   logic [PW-1:0] pg0_ff, pg1_ff, pg_ff;
   logic [2:0]    lo_ff, hi_ff;
   logic          skip_ff;

   logic          w_vld_ff;
   logic [AW-1:0] w_addr_ff;
   logic [7:0]    w_mask_ff;

   logic    res_pix_ff;
   logic [7:0] res_byte_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   // setup stage
   logic signed [CoordW-1:0] xa_in, xb_in, ya_in, yb_in;
   logic                     none_in;
   // clip stage
   logic signed [CoordW-1:0] cl_in, ch_in, rl_in, rh_in;
   logic                     empty_in;
   // sweep
   logic [AW-1:0] run_addr;
   logic [7:0]    run_mask;
   logic [7:0]    run_bits;
   logic [2:0]    run_lo, run_hi;
   logic          run_first;
   // write stage
   logic [7:0]    rd_data;
   logic [7:0]    wr_data;
   logic          wr_en;
   logic          slot_free;

   always_comb begin
      logic signed [CoordW-1:0] xe, ye, ypage;
      xe      = {{(CoordW-16){item_ff.x[15]}}, item_ff.x};
      ye      = {{(CoordW-16){item_ff.y[15]}}, item_ff.y};
      ypage   = {ye[CoordW-1:3], 3'b000};
      xa_in   = xe;
      xb_in   = xe;
      ya_in   = ye;
      yb_in   = ye;
      none_in = 1'b0;
      case (item_ff.func)
         FN_CLEAR_AREA, FN_INVERT_AREA: begin
            xb_in   = xe + CoordW'(item_ff.area_width) - CoordW'(1);
            yb_in   = ye + CoordW'(item_ff.area_height) - CoordW'(1);
            none_in = (item_ff.area_width == 8'd0) || (item_ff.area_height == 8'd0);
         end
         FN_BLIT: begin
            ya_in = ypage;
            yb_in = ypage + CoordW'(15);
         end
         FN_READ_BYTE: begin
            ya_in = ypage;
            yb_in = ypage + CoordW'(7);
         end
         FN_CLEAR_ALL, FN_INVERT_ALL: begin
            xa_in = '0;
            xb_in = COL_LAST;
            ya_in = '0;
            yb_in = ROW_LAST;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cl_in    = (xa_ff < 0) ? '0 : xa_ff;
      ch_in    = (xb_ff > COL_LAST) ? COL_LAST : xb_ff;
      rl_in    = (ya_ff < 0) ? '0 : ya_ff;
      rh_in    = (yb_ff > ROW_LAST) ? ROW_LAST : yb_ff;
      empty_in = none_ff || (xb_ff < 0) || (xa_ff > COL_LAST) || (xa_ff > xb_ff)
              || (yb_ff < 0) || (ya_ff > ROW_LAST) || (ya_ff > yb_ff);
   end

   always_comb begin
      run_addr  = AW'(32'(pg_ff) * COLUMNS + 32'(col_ff));
      run_lo    = (pg_ff == pg0_ff) ? lo_ff : 3'd0;
      run_hi    = (pg_ff == pg1_ff) ? hi_ff : 3'd7;
      run_mask  = (8'hFF << run_lo) & (8'hFF >> (3'd7 - run_hi));
      run_first = (pg_ff == pg0_ff) && !skip_ff;
      run_bits  = run_mask;
      if (func_ff == FN_BLIT) begin
         run_bits = run_first ? shift_ff[7:0] : shift_ff[15:8];
      end
   end

   always_comb begin
      wr_en   = w_vld_ff;
      wr_data = rd_data;
      case (func_ff)
         FN_SET_PIXEL, FN_BLIT:         wr_data = rd_data | w_mask_ff;
         FN_CLEAR_AREA, FN_CLEAR_ALL:   wr_data = rd_data & ~w_mask_ff;
         FN_INVERT_AREA, FN_INVERT_ALL: wr_data = rd_data ^ w_mask_ff;
         default:                       wr_en   = 1'b0;
      endcase
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         func_ff      <= FN_CLEAR_ALL;
         quiet_ff     <= 1'b1;
         c0_ff        <= '0;
         c1_ff        <= COL_MAX;
         col_ff       <= '0;
         pg0_ff       <= '0;
         pg1_ff       <= PAGE_MAX;
         pg_ff        <= '0;
         lo_ff        <= 3'd0;
         hi_ff        <= 3'd7;
         skip_ff      <= 1'b0;
         w_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_vld_ff  <= (state_ff == ST_RUN);
         w_addr_ff <= run_addr;
         w_mask_ff <= run_bits;

         if (w_vld_ff) begin
            res_pix_ff  <= (func_ff == FN_READ_PIXEL) && ((rd_data & w_mask_ff) != 8'd0);
            res_byte_ff <= (func_ff == FN_READ_BYTE) ? rd_data : 8'd0;
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_item;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               func_ff  <= item_ff.func;
               xa_ff    <= xa_in;
               xb_ff    <= xb_in;
               ya_ff    <= ya_in;
               yb_ff    <= yb_in;
               none_ff  <= none_in;
               shift_ff <= {8'd0, item_ff.image_byte} << item_ff.y[2:0];
               state_ff <= ST_CLIP;
            end
            ST_CLIP: begin
               c0_ff       <= CW'(cl_in);
               c1_ff       <= CW'(ch_in);
               col_ff      <= CW'(cl_in);
               pg0_ff      <= PW'(rl_in >>> 3);
               pg1_ff      <= PW'(rh_in >>> 3);
               pg_ff       <= PW'(rl_in >>> 3);
               lo_ff       <= rl_in[2:0];
               hi_ff       <= rh_in[2:0];
               skip_ff     <= (ya_ff < 0);
               res_pix_ff  <= 1'b0;
               res_byte_ff <= 8'd0;
               state_ff    <= empty_in ? ST_FINISH : ST_RUN;
            end
            ST_RUN: begin
               if (col_ff == c1_ff) begin
                  col_ff <= c0_ff;
                  if (pg_ff == pg1_ff) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     pg_ff <= pg_ff + 1'b1;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff            <= !quiet_ff;
                  rsp_item_ff.pixel_value <= res_pix_ff;
                  rsp_item_ff.byte_value  <= res_byte_ff;
                  quiet_ff                <= 1'b0;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   mpfe_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (w_addr_ff),
      .wr_data (wr_data),
      .rd_addr (run_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire
